// File: rtl/tht_pkg.sv
// Shared types and constants for the touch region hit test block.
// Used by tht_ctrl, tht_dp and touch_region_hit_test_top; depends on nothing.
`default_nettype none

package tht_pkg;

	localparam int FUNC_W    = 2;
	localparam int INDEX_W   = 4;
	localparam int BYTE_W    = 8;
	localparam int ENTRY_W   = 4 * BYTE_W;
	localparam int HIT_IDX_W = 4;

	// Item functions
	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SCAN  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TEST  = 2'd2;

	// First-byte markers and the value of an entry never written
	localparam logic [BYTE_W-1:0]  MARK_END    = 8'hff;
	localparam logic [BYTE_W-1:0]  MARK_CIRCLE = 8'hfe;
	localparam logic [ENTRY_W-1:0] ENTRY_EMPTY = 32'hffff_ffff;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // latch item fields, set read address
		logic wr_en;     // write the table entry from the input ports
		logic issue;     // read one entry and advance the address
		logic flush;     // drop entries still in flight
		logic res_zero;  // stage a no-hit result
		logic res_load;  // stage the evaluated result
		logic out_load;  // move the staged result to the output register
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic idx_ok;      // input index lies inside the table
		logic issue_last;  // address being issued is the final one
		logic eval_stop;   // evaluated entry ends the item
	} dp_status_t;

endpackage

`default_nettype wire

// File: rtl/touch_region_hit_test_top.sv
// Top level of the touch region hit test block: ties the controller to the datapath.
// Depends on tht_pkg, tht_ctrl and tht_dp.
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid / in_stall  func, index, byte_a..byte_d, rects_only,
//                                touch_active, point_x, point_y
// output    out_valid / out_stall hit, hit_index
//
// A write, an inactive touch, an unused function or an out-of-range single test
// answers without reading the table. A scan walks the table through the
// one-entry-per-cycle read port and a two-stage test pipeline; a single test reads
// one entry. Reset clears every written flag at once, so the table reads as end
// markers immediately; no clearing pass. A finished result waits in the output
// register while the next transaction is taken; a stalled output holds its payload.

module touch_region_hit_test_top #(
	parameter int REGION_ENTRIES = 16
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire [tht_pkg::FUNC_W-1:0]     func,
	input  wire [tht_pkg::INDEX_W-1:0]    index,
	input  wire [tht_pkg::BYTE_W-1:0]     byte_a,
	input  wire [tht_pkg::BYTE_W-1:0]     byte_b,
	input  wire [tht_pkg::BYTE_W-1:0]     byte_c,
	input  wire [tht_pkg::BYTE_W-1:0]     byte_d,
	input  wire                           rects_only,
	input  wire                           touch_active,
	input  wire [tht_pkg::BYTE_W-1:0]     point_x,
	input  wire [tht_pkg::BYTE_W-1:0]     point_y,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic                          hit,
	output logic [tht_pkg::HIT_IDX_W-1:0] hit_index
);

	tht_pkg::ctl_cmd_t   cmd;
	tht_pkg::dp_status_t st;

	// Sequence each transaction: accept, walk the table, stage and hand off the result
	tht_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.func         (func),
		.touch_active (touch_active),
		.out_stall    (out_stall),
		.st           (st),
		.cmd          (cmd),
		.in_stall     (in_stall),
		.out_valid    (out_valid)
	);

	// Hold the table, test one entry per cycle, hold the result
	tht_dp #(
		.REGION_ENTRIES (REGION_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.func       (func),
		.index      (index),
		.byte_a     (byte_a),
		.byte_b     (byte_b),
		.byte_c     (byte_c),
		.byte_d     (byte_d),
		.rects_only (rects_only),
		.point_x    (point_x),
		.point_y    (point_y),
		.hit        (hit),
		.hit_index  (hit_index)
	);

endmodule

`default_nettype wire

// File: rtl/tht_ctrl.sv
// Controller state machine for the touch region hit test block.
// Depends on tht_pkg; drives tht_dp through ctl_cmd_t and reads dp_status_t.
`default_nettype none

module tht_ctrl (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	input  wire [tht_pkg::FUNC_W-1:0]  func,
	input  wire                        touch_active,
	input  wire                        out_stall,
	input  wire tht_pkg::dp_status_t   st,
	output tht_pkg::ctl_cmd_t          cmd,
	output logic                       in_stall,
	output logic                       out_valid
);

	tht_pkg::state_t state_q;
	tht_pkg::state_t state_nxt;
	logic            out_valid_q;
	logic            accept;
	logic            needs_scan;
	logic            out_free;

	assign in_stall = (state_q != tht_pkg::ST_IDLE);
	assign accept   = in_valid && (state_q == tht_pkg::ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// Scans and in-range single tests with an active touch go through the table; all else answers at once
	assign needs_scan = touch_active &&
		((func == tht_pkg::FUNC_SCAN) || ((func == tht_pkg::FUNC_TEST) && st.idx_ok));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tht_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = needs_scan ? tht_pkg::ST_ISSUE : tht_pkg::ST_DONE;
				end
			end
			tht_pkg::ST_ISSUE: begin
				priority if (st.eval_stop) begin
					state_nxt = tht_pkg::ST_DONE;
				end else if (st.issue_last) begin
					state_nxt = tht_pkg::ST_WAIT;
				end
			end
			tht_pkg::ST_WAIT: begin
				if (st.eval_stop) begin
					state_nxt = tht_pkg::ST_DONE;
				end
			end
			tht_pkg::ST_DONE: begin
				if (out_free) begin
					state_nxt = tht_pkg::ST_IDLE;
				end
			end
			default: state_nxt = tht_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			tht_pkg::ST_IDLE: begin
				if (accept) begin
					cmd.load     = needs_scan;
					cmd.res_zero = !needs_scan;
					cmd.wr_en    = (func == tht_pkg::FUNC_WRITE) && st.idx_ok;
				end
			end
			tht_pkg::ST_ISSUE: begin
				cmd.issue    = !st.eval_stop;
				cmd.res_load = st.eval_stop;
				cmd.flush    = st.eval_stop;
			end
			tht_pkg::ST_WAIT: begin
				cmd.res_load = st.eval_stop;
				cmd.flush    = st.eval_stop;
			end
			tht_pkg::ST_DONE: begin
				cmd.out_load = out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tht_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/tht_dp.sv
// Datapath for the touch region hit test block: region table, read pipeline,
// rectangle and circle tests, result staging and output register. Depends on tht_pkg.
`default_nettype none

module tht_dp #(
	parameter int REGION_ENTRIES = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire tht_pkg::ctl_cmd_t       cmd,
	output tht_pkg::dp_status_t          st,
	input  wire [tht_pkg::FUNC_W-1:0]    func,
	input  wire [tht_pkg::INDEX_W-1:0]   index,
	input  wire [tht_pkg::BYTE_W-1:0]    byte_a,
	input  wire [tht_pkg::BYTE_W-1:0]    byte_b,
	input  wire [tht_pkg::BYTE_W-1:0]    byte_c,
	input  wire [tht_pkg::BYTE_W-1:0]    byte_d,
	input  wire                          rects_only,
	input  wire [tht_pkg::BYTE_W-1:0]    point_x,
	input  wire [tht_pkg::BYTE_W-1:0]    point_y,
	output logic                         hit,
	output logic [tht_pkg::HIT_IDX_W-1:0] hit_index
);

	localparam int AW = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(REGION_ENTRIES - 1);
	localparam int BW = tht_pkg::BYTE_W;
	localparam int SQ_W = 2 * BW;

	// Region table and per-entry written flags
	logic [tht_pkg::ENTRY_W-1:0] mem [REGION_ENTRIES];
	logic [REGION_ENTRIES-1:0]   vld_q;

	// Latched item
	logic [BW-1:0] x_q;
	logic [BW-1:0] y_q;
	logic          rects_q;
	logic          scan_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] wr_addr;

	// Read stage
	logic                        v_s1;
	logic [tht_pkg::ENTRY_W-1:0] rd_s1;
	logic                        wr_s1;
	logic [AW-1:0]               idx_s1;
	logic                        last_s1;
	logic [tht_pkg::ENTRY_W-1:0] ent;
	logic [BW-1:0]               e_top, e_bot, e_left, e_right;

	// Test stage
	logic                v_s2;
	logic [AW-1:0]       idx_s2;
	logic                last_s2;
	logic                end_s2;
	logic                circ_s2;
	logic                rect_in_s2;
	logic [SQ_W-1:0]     dx2_s2;
	logic [SQ_W-1:0]     dy2_s2;
	logic [SQ_W-1:0]     r2_s2;

	logic [BW:0]         ax, bx, ay, by;
	logic signed [BW:0]  dx, dy;
	logic signed [2*BW+1:0] dx_sq, dy_sq;
	logic [SQ_W-1:0]     r_sq;
	logic [SQ_W:0]       dist_sq;
	logic                circ_in;
	logic                end_stop;
	logic                eval_hit;

	// Staged result and output register
	logic                          res_hit_q;
	logic [tht_pkg::HIT_IDX_W-1:0] res_idx_q;
	logic                          out_hit_q;
	logic [tht_pkg::HIT_IDX_W-1:0] out_idx_q;

	assign wr_addr = AW'(index);
	assign st.idx_ok = (32'(index) < 32'(REGION_ENTRIES));
	assign st.issue_last = !scan_q || (addr_q == LAST_ADDR);

	// Table write and read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= {byte_a, byte_b, byte_c, byte_d};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_s1   <= mem[addr_q];
			wr_s1   <= vld_q[addr_q];
			idx_s1  <= addr_q;
			last_s1 <= st.issue_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Item latch and read address
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= point_x;
			y_q     <= point_y;
			scan_q  <= (func == tht_pkg::FUNC_SCAN);
			rects_q <= (func == tht_pkg::FUNC_SCAN) && rects_only;
			addr_q  <= (func == tht_pkg::FUNC_SCAN) ? '0 : wr_addr;
		end else if (cmd.issue) begin
			addr_q <= addr_q + 1'b1;
		end
	end

	// Unwritten entries read as end markers
	assign ent = wr_s1 ? rd_s1 : tht_pkg::ENTRY_EMPTY;
	assign e_top   = ent[4*BW-1:3*BW];
	assign e_bot   = ent[3*BW-1:2*BW];
	assign e_left  = ent[2*BW-1:BW];
	assign e_right = ent[BW-1:0];

	// Wrapping differences keep their order in one extra bit
	always_comb begin
		ax = {1'b0, x_q} - {1'b0, e_left};
		bx = {1'b0, e_right} - {1'b0, e_left};
		ay = {1'b0, y_q} - {1'b0, e_top};
		by = {1'b0, e_bot} - {1'b0, e_top};
		dx = $signed({1'b0, e_bot}) - $signed({1'b0, x_q});
		dy = $signed({1'b0, e_left}) - $signed({1'b0, y_q});
		dx_sq = dx * dx;
		dy_sq = dy * dy;
		r_sq  = e_right * e_right;
	end

	always_ff @(posedge clk) begin
		idx_s2     <= idx_s1;
		last_s2    <= last_s1;
		end_s2     <= (e_top == tht_pkg::MARK_END);
		circ_s2    <= (e_top == tht_pkg::MARK_CIRCLE) && !rects_q;
		rect_in_s2 <= (ax < bx) && (ay < by);
		dx2_s2     <= dx_sq[SQ_W-1:0];
		dy2_s2     <= dy_sq[SQ_W-1:0];
		r2_s2      <= r_sq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue && !cmd.flush;
			v_s2 <= v_s1 && !cmd.flush;
		end
	end

	// Decide on the entry in the test stage
	assign dist_sq  = {1'b0, dx2_s2} + {1'b0, dy2_s2};
	assign circ_in  = dist_sq < {1'b0, r2_s2};
	assign end_stop = scan_q && end_s2;
	assign eval_hit = !end_stop && (circ_s2 ? circ_in : rect_in_s2);
	assign st.eval_stop = v_s2 && (last_s2 || end_stop || eval_hit);

	always_ff @(posedge clk) begin
		priority if (cmd.res_zero) begin
			res_hit_q <= 1'b0;
			res_idx_q <= '0;
		end else if (cmd.res_load) begin
			res_hit_q <= eval_hit;
			res_idx_q <= eval_hit ? tht_pkg::HIT_IDX_W'(idx_s2) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_hit_q <= res_hit_q;
			out_idx_q <= res_idx_q;
		end
	end

	assign hit       = out_hit_q;
	assign hit_index = out_idx_q;

endmodule

`default_nettype wire
